// ===== hw/rtl/polygon_area_perimeter_top_defines.svh =====
// Assertion macros used by the checker file of the polygon measuring block.
`ifndef POLYGON_AREA_PERIMETER_TOP_DEFINES_SVH
`define POLYGON_AREA_PERIMETER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PAP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("polygon block check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("polygon block check failed");

`endif

// ===== hw/rtl/pap_pkg.sv =====
package pap_pkg;

    // Field widths.
    localparam int COORD_W  = 24;
    localparam int RADIUS_W = 24;
    localparam int AREA_W   = 63;
    localparam int LEN_W    = 40;
    localparam int CNT_W    = 16;
    localparam int CROSS_W  = 64;

    // Datapath widths derived from the coordinate width.
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int DSQ_W    = PROD_W;
    localparam int ROOT_W   = DSQ_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SQ_CNT_W = $clog2(ROOT_W);

    // A polygon needs this many vertices before it can be closed.
    localparam logic [CNT_W-1:0] MIN_VERTS = CNT_W'(3);

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_CANCEL = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CK_DX,
        ST_CK_DY,
        ST_CK_R,
        ST_CK_CMP,
        ST_M_DX,
        ST_M_DY,
        ST_M_C1,
        ST_M_C2,
        ST_SQ_INIT,
        ST_SQRT,
        ST_ACC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } item_t;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [LEN_W-1:0]  perimeter;
        logic [CNT_W-1:0]  vertex_count;
        logic              overflow;
    } result_t;

endpackage

// ===== hw/rtl/polygon_area_perimeter_top.sv =====
// Polygon area and perimeter meter.
// Input channel (item_valid/item_ready/item) carries one action per beat: add a
// vertex, finish the polygon or cancel it. Coordinates are signed Q12.12.
// Result channel (result_valid/result_ready/result) carries one beat per closed
// polygon: area (Q39.24), perimeter (Q28.12), vertex count and overflow flag.
// cfg_wr_en/cfg_wr_data write close_radius; write it only while idle.
// The first vertex, cancel and a short finish are taken without leaving idle. Every
// other edge goes through one shared 25x25 multiplier and a one-bit-per-cycle
// square root, after the closing radius test when that runs first. The result
// beat of a closed polygon is registered once its closing edge is folded into
// the sums. item_ready is low while a vertex is being processed.
// Reset clears the polygon state, close_radius and the result valid flag, not the payload.
// If the receiver stalls, the finished result waits in the output register;
// new vertices are still taken, and only a second result waits for the first.
module polygon_area_perimeter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  pap_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output pap_pkg::result_t                result,
    input  logic                            cfg_wr_en,
    input  logic [pap_pkg::RADIUS_W-1:0]    cfg_wr_data
);

    pap_pkg::state_t state_reg, state_next;

    logic [pap_pkg::RADIUS_W-1:0]       radius_reg;
    logic signed [pap_pkg::COORD_W-1:0] first_x_reg, first_y_reg;
    logic signed [pap_pkg::COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [pap_pkg::COORD_W-1:0] vx_reg, vy_reg;
    logic [pap_pkg::CNT_W-1:0]          count_reg;
    logic signed [pap_pkg::CROSS_W-1:0] cross_sum_reg;
    logic [pap_pkg::LEN_W-1:0]          length_sum_reg;
    logic                               sat_reg;
    logic                               close_reg;

    logic signed [pap_pkg::PROD_W-1:0]  prod_reg;
    logic [pap_pkg::DSQ_W-1:0]          dsq_reg;
    logic signed [pap_pkg::PROD_W-1:0]  edge_c_reg;
    logic [pap_pkg::DSQ_W-1:0]          sq_src_reg;
    logic [pap_pkg::REM_W-1:0]          rem_reg;
    logic [pap_pkg::ROOT_W-1:0]         root_reg;
    logic [pap_pkg::SQ_CNT_W-1:0]       sq_cnt_reg;

    logic                               out_valid_reg;
    pap_pkg::result_t                   out_reg;

    logic signed [pap_pkg::DIFF_W-1:0]  op_a, op_b;
    logic signed [pap_pkg::PROD_W-1:0]  mul_full;
    logic signed [pap_pkg::COORD_W-1:0] bx, by;
    logic signed [pap_pkg::DIFF_W-1:0]  edge_dx, edge_dy, chk_dx, chk_dy;
    logic                               accept;
    logic                               emit_fire;
    logic                               sq_last;
    logic [pap_pkg::REM_W-1:0]          rem_shift, trial;
    logic                               fits;
    logic signed [pap_pkg::CROSS_W:0]   cross_wide;
    logic [pap_pkg::LEN_W:0]            len_wide;
    logic [pap_pkg::CROSS_W-1:0]        cross_abs;
    logic                               cross_ovf;
    logic                               len_ovf;
    logic                               count_ovf;

    assign accept    = item_valid && item_ready;
    assign emit_fire = (state_reg == pap_pkg::ST_EMIT) && (!out_valid_reg || result_ready);
    assign sq_last   = (sq_cnt_reg == pap_pkg::SQ_CNT_W'(pap_pkg::ROOT_W - 1));

    // The far end of the edge is either the new vertex or the first vertex.
    assign bx = close_reg ? first_x_reg : vx_reg;
    assign by = close_reg ? first_y_reg : vy_reg;

    // Coordinate differences, one bit wider than the coordinates.
    assign edge_dx = {prev_x_reg[pap_pkg::COORD_W-1], prev_x_reg}
                   - {bx[pap_pkg::COORD_W-1], bx};
    assign edge_dy = {prev_y_reg[pap_pkg::COORD_W-1], prev_y_reg}
                   - {by[pap_pkg::COORD_W-1], by};
    assign chk_dx  = {first_x_reg[pap_pkg::COORD_W-1], first_x_reg}
                   - {vx_reg[pap_pkg::COORD_W-1], vx_reg};
    assign chk_dy  = {first_y_reg[pap_pkg::COORD_W-1], first_y_reg}
                   - {vy_reg[pap_pkg::COORD_W-1], vy_reg};

    // The shared signed multiplier; its product is always registered.
    assign mul_full = op_a * op_b;

    // One square root step: bring down two bits and try to subtract.
    assign rem_shift = {rem_reg[pap_pkg::REM_W-3:0], sq_src_reg[pap_pkg::DSQ_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    // Wide sums used for saturation checks.
    assign cross_wide = {cross_sum_reg[pap_pkg::CROSS_W-1], cross_sum_reg}
                      + (pap_pkg::CROSS_W + 1)'(edge_c_reg);
    assign len_wide   = {1'b0, length_sum_reg} + (pap_pkg::LEN_W + 1)'(root_reg);

    // Saturation conditions for the sums and the vertex count.
    assign cross_ovf = (cross_wide[pap_pkg::CROSS_W] != cross_wide[pap_pkg::CROSS_W-1]);
    assign len_ovf   = len_wide[pap_pkg::LEN_W];
    assign count_ovf = !close_reg && (count_reg == '1);

    // Magnitude of the cross sum for the area.
    assign cross_abs = cross_sum_reg[pap_pkg::CROSS_W-1]
                     ? pap_pkg::CROSS_W'(-cross_sum_reg)
                     : pap_pkg::CROSS_W'(cross_sum_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pap_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.action)
                        pap_pkg::ACT_ADD:
                        begin
                            if (count_reg == '0)
                                state_next = pap_pkg::ST_IDLE;
                            else if (count_reg >= pap_pkg::MIN_VERTS && radius_reg != '0)
                                state_next = pap_pkg::ST_CK_DX;
                            else
                                state_next = pap_pkg::ST_M_DX;
                        end
                        pap_pkg::ACT_FINISH:
                        begin
                            if (count_reg >= pap_pkg::MIN_VERTS)
                                state_next = pap_pkg::ST_M_DX;
                        end
                        default:
                            state_next = pap_pkg::ST_IDLE;
                    endcase
                end
            end
            pap_pkg::ST_CK_DX:   state_next = pap_pkg::ST_CK_DY;
            pap_pkg::ST_CK_DY:   state_next = pap_pkg::ST_CK_R;
            pap_pkg::ST_CK_R:    state_next = pap_pkg::ST_CK_CMP;
            pap_pkg::ST_CK_CMP:  state_next = pap_pkg::ST_M_DX;
            pap_pkg::ST_M_DX:    state_next = pap_pkg::ST_M_DY;
            pap_pkg::ST_M_DY:    state_next = pap_pkg::ST_M_C1;
            pap_pkg::ST_M_C1:    state_next = pap_pkg::ST_M_C2;
            pap_pkg::ST_M_C2:    state_next = pap_pkg::ST_SQ_INIT;
            pap_pkg::ST_SQ_INIT: state_next = pap_pkg::ST_SQRT;
            pap_pkg::ST_SQRT:
            begin
                if (sq_last)
                    state_next = pap_pkg::ST_ACC;
            end
            pap_pkg::ST_ACC:
                state_next = close_reg ? pap_pkg::ST_EMIT : pap_pkg::ST_IDLE;
            pap_pkg::ST_EMIT:
            begin
                if (emit_fire)
                    state_next = pap_pkg::ST_IDLE;
            end
            default:
                state_next = pap_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: ready and multiplier operand selection.
    always_comb
    begin
        item_ready = (state_reg == pap_pkg::ST_IDLE);
        op_a       = '0;
        op_b       = '0;
        unique case (state_reg)
            pap_pkg::ST_CK_DX:
            begin
                op_a = chk_dx;
                op_b = chk_dx;
            end
            pap_pkg::ST_CK_DY:
            begin
                op_a = chk_dy;
                op_b = chk_dy;
            end
            pap_pkg::ST_CK_R:
            begin
                op_a = {1'b0, radius_reg};
                op_b = {1'b0, radius_reg};
            end
            pap_pkg::ST_M_DX:
            begin
                op_a = edge_dx;
                op_b = edge_dx;
            end
            pap_pkg::ST_M_DY:
            begin
                op_a = edge_dy;
                op_b = edge_dy;
            end
            pap_pkg::ST_M_C1:
            begin
                op_a = {prev_x_reg[pap_pkg::COORD_W-1], prev_x_reg};
                op_b = {by[pap_pkg::COORD_W-1], by};
            end
            pap_pkg::ST_M_C2:
            begin
                op_a = {bx[pap_pkg::COORD_W-1], bx};
                op_b = {prev_y_reg[pap_pkg::COORD_W-1], prev_y_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Sequencer state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pap_pkg::ST_IDLE;
            radius_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                radius_reg <= cfg_wr_data;
        end
    end

    // Polygon state: first and previous vertex, count, sums and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            count_reg      <= '0;
            cross_sum_reg  <= '0;
            length_sum_reg <= '0;
            sat_reg        <= 1'b0;
            close_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                unique case (item.action)
                    pap_pkg::ACT_ADD:
                    begin
                        close_reg <= 1'b0;
                        if (count_reg == '0)
                        begin
                            first_x_reg <= item.x;
                            first_y_reg <= item.y;
                            prev_x_reg  <= item.x;
                            prev_y_reg  <= item.y;
                            count_reg   <= pap_pkg::CNT_W'(1);
                        end
                    end
                    pap_pkg::ACT_FINISH:
                        close_reg <= 1'b1;
                    pap_pkg::ACT_CANCEL:
                    begin
                        first_x_reg    <= '0;
                        first_y_reg    <= '0;
                        prev_x_reg     <= '0;
                        prev_y_reg     <= '0;
                        count_reg      <= '0;
                        cross_sum_reg  <= '0;
                        length_sum_reg <= '0;
                        sat_reg        <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // A vertex strictly inside the radius closes the polygon instead.
            if (state_reg == pap_pkg::ST_CK_CMP && dsq_reg < $unsigned(prod_reg))
                close_reg <= 1'b1;

            // Fold the finished edge into both sums with saturation.
            if (state_reg == pap_pkg::ST_ACC)
            begin
                if (cross_ovf)
                begin
                    cross_sum_reg <= cross_wide[pap_pkg::CROSS_W]
                        ? {1'b1, {(pap_pkg::CROSS_W-1){1'b0}}}
                        : {1'b0, {(pap_pkg::CROSS_W-1){1'b1}}};
                end
                else
                begin
                    cross_sum_reg <= cross_wide[pap_pkg::CROSS_W-1:0];
                end

                if (len_ovf)
                    length_sum_reg <= '1;
                else
                    length_sum_reg <= len_wide[pap_pkg::LEN_W-1:0];

                if (cross_ovf || len_ovf || count_ovf)
                    sat_reg <= 1'b1;

                if (!close_reg)
                begin
                    prev_x_reg <= vx_reg;
                    prev_y_reg <= vy_reg;
                    if (count_reg != '1)
                        count_reg <= count_reg + pap_pkg::CNT_W'(1);
                end
            end

            // The result has been handed over, start a fresh polygon.
            if (emit_fire)
            begin
                first_x_reg    <= '0;
                first_y_reg    <= '0;
                prev_x_reg     <= '0;
                prev_y_reg     <= '0;
                count_reg      <= '0;
                cross_sum_reg  <= '0;
                length_sum_reg <= '0;
                sat_reg        <= 1'b0;
                close_reg      <= 1'b0;
            end
        end
    end

    // Arithmetic working registers: product, squared distance, cross term, root.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full;

        if (accept)
        begin
            vx_reg <= item.x;
            vy_reg <= item.y;
        end

        unique case (state_reg)
            pap_pkg::ST_CK_DY, pap_pkg::ST_M_DY:
                dsq_reg <= $unsigned(prod_reg);
            pap_pkg::ST_CK_R, pap_pkg::ST_M_C1:
                dsq_reg <= dsq_reg + $unsigned(prod_reg);
            pap_pkg::ST_M_C2:
                edge_c_reg <= prod_reg;
            pap_pkg::ST_SQ_INIT:
            begin
                edge_c_reg <= edge_c_reg - prod_reg;
                sq_src_reg <= dsq_reg;
                rem_reg    <= '0;
                root_reg   <= '0;
                sq_cnt_reg <= '0;
            end
            pap_pkg::ST_SQRT:
            begin
                rem_reg    <= fits ? rem_shift - trial : rem_shift;
                root_reg   <= {root_reg[pap_pkg::ROOT_W-2:0], fits};
                sq_src_reg <= {sq_src_reg[pap_pkg::DSQ_W-3:0], 2'b00};
                sq_cnt_reg <= sq_cnt_reg + pap_pkg::SQ_CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_fire)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register: payload.
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_reg.area         <= cross_abs[pap_pkg::CROSS_W-1:1];
            out_reg.perimeter    <= length_sum_reg;
            out_reg.vertex_count <= count_reg;
            out_reg.overflow     <= sat_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== hw/rtl/pap_checker.sv =====
`include "polygon_area_perimeter_top_defines.svh"

module pap_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input pap_pkg::result_t result
);

    // A measured polygon always has at least three vertices.
    `PAP_ASSERT_NOW(a_min_vertices, result_valid, result.vertex_count >= pap_pkg::MIN_VERTS)

    // A new result only appears at the end of a busy stretch.
    `PAP_ASSERT_NOW(a_result_after_busy, $rose(result_valid), $past(!item_ready))

    // A stalled result beat holds its payload.
    `PAP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
                     result_valid && $stable(result))

endmodule

bind polygon_area_perimeter_top pap_checker u_pap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ===== tb/tb_polygon_area_perimeter_top.sv =====
`timescale 1ns / 100ps

// Tracks the polygon being built and keeps the measurements that the block owes.
class shoelace_tracker;
    localparam longint CROSS_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint CROSS_BOTTOM = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;
    localparam logic [63:0] LEN_TOP = (64'd1 << 40) - 64'd1;
    localparam int unsigned COUNT_TOP = 65535;

    longint first_x;
    longint first_y;
    longint last_x;
    longint last_y;
    int unsigned held;
    longint cross_sum;
    logic [63:0] length_sum;
    bit sat_flag;
    logic [63:0] radius;
    pap_pkg::result_t owed_q[$];
    int mismatches;
    int polygons;

    function new();
        clear();
        radius = 0;
        mismatches = 0;
        polygons = 0;
    endfunction

    function void clear();
        first_x = 0;
        first_y = 0;
        last_x = 0;
        last_y = 0;
        held = 0;
        cross_sum = 0;
        length_sum = 0;
        sat_flag = 1'b0;
    endfunction

    function void set_radius(logic [23:0] r);
        radius = {40'd0, r};
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // Squared distance between two points, exact on integers.
    function logic [63:0] span_sq(longint ax, longint ay, longint bx, longint by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        return $unsigned(dx * dx + dy * dy);
    endfunction

    // Floor of the square root, two bits of the radicand per step.
    function logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] rest;
        logic [63:0] root;
        logic [63:0] probe;
        rest = v;
        root = 64'd0;
        probe = 64'd1 << 62;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 64'd0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Adds one edge to the shoelace sum and to the perimeter, both saturating.
    function void add_edge(longint ax, longint ay, longint bx, longint by);
        longint c;
        logic [63:0] grown;
        c = ax * by - bx * ay;
        if (c > 0 && cross_sum > CROSS_TOP - c)
        begin
            cross_sum = CROSS_TOP;
            sat_flag = 1'b1;
        end
        else if (c < 0 && cross_sum < CROSS_BOTTOM - c)
        begin
            cross_sum = CROSS_BOTTOM;
            sat_flag = 1'b1;
        end
        else
        begin
            cross_sum = cross_sum + c;
        end
        grown = length_sum + int_sqrt(span_sq(ax, ay, bx, by));
        if (grown > LEN_TOP)
        begin
            grown = LEN_TOP;
            sat_flag = 1'b1;
        end
        length_sum = grown;
    endfunction

    // Closing edge, then the measurement is owed and the polygon starts over.
    function void close_polygon();
        pap_pkg::result_t r;
        logic [63:0] magnitude;
        add_edge(last_x, last_y, first_x, first_y);
        magnitude = (cross_sum < 0) ? -$unsigned(cross_sum) : $unsigned(cross_sum);
        r.area = magnitude[63:1];
        r.perimeter = length_sum[39:0];
        r.vertex_count = held[15:0];
        r.overflow = sat_flag;
        owed_q = {owed_q, r};
        clear();
    endfunction

    // Called for every accepted input beat.
    function void apply_action(pap_pkg::item_t it);
        longint x;
        longint y;
        x = $signed(it.x);
        y = $signed(it.y);
        case (it.action)
            pap_pkg::ACT_CANCEL:
                clear();
            pap_pkg::ACT_FINISH:
                if (held >= 3)
                    close_polygon();
            pap_pkg::ACT_ADD:
            begin
                if (held == 0)
                begin
                    first_x = x;
                    first_y = y;
                    last_x = x;
                    last_y = y;
                    held = 1;
                end
                else if (held >= 3 && radius != 0 &&
                         span_sq(first_x, first_y, x, y) < radius * radius)
                begin
                    // A vertex close to the first one closes and is dropped.
                    close_polygon();
                end
                else
                begin
                    add_edge(last_x, last_y, x, y);
                    last_x = x;
                    last_y = y;
                    if (held >= COUNT_TOP)
                        sat_flag = 1'b1;
                    else
                        held++;
                end
            end
            default:
                ;
        endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Called for every accepted result beat.
    task match_result(pap_pkg::result_t got);
        pap_pkg::result_t want;
        if (owed_q.size() == 0)
        begin
            report("result beat with nothing owed", {1'b0, got.area}, 64'd0);
            return;
        end
        want = owed_q.pop_front();
        polygons++;
        if (got.area !== want.area)
            report("area", {1'b0, got.area}, {1'b0, want.area});
        if (got.perimeter !== want.perimeter)
            report("perimeter", {24'd0, got.perimeter}, {24'd0, want.perimeter});
        if (got.vertex_count !== want.vertex_count)
            report("vertex_count", {48'd0, got.vertex_count}, {48'd0, want.vertex_count});
        if (got.overflow !== want.overflow)
            report("overflow", {63'd0, got.overflow}, {63'd0, want.overflow});
    endtask
endclass

module tb_polygon_area_perimeter_top;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int HOLD_OFF = 40;
    localparam int QUIET_LIMIT = 4000;
    localparam longint COORD_TOP = 64'sd8388607;
    localparam longint COORD_BOTTOM = -64'sd8388608;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    pap_pkg::item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    pap_pkg::result_t result;
    logic cfg_wr_en = 1'b0;
    logic [pap_pkg::RADIUS_W-1:0] cfg_wr_data = '0;

    shoelace_tracker board;
    bit steady = 1'b0;
    int quiet_cycles = 0;
    int beats_in = 0;

    polygon_area_perimeter_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #4 clk = ~clk;

    // Result side: check accepted beats, count quiet cycles, stall at random.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.match_result(result);
        if (rst_n && ((result_valid && result_ready) || (item_valid && item_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        result_ready <= steady || ($urandom_range(99) >= 37);
    end

    // Watchdog: the run ends if nothing moves for too long.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d quiet cycles", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic pap_pkg::item_t make_item(logic [1:0] act, longint x, longint y);
        pap_pkg::item_t it;
        it.action = act;
        it.x = x[pap_pkg::COORD_W-1:0];
        it.y = y[pap_pkg::COORD_W-1:0];
        return it;
    endfunction

    function automatic longint full_coord();
        logic signed [pap_pkg::COORD_W-1:0] raw;
        raw = pap_pkg::COORD_W'($urandom());
        return raw;
    endfunction

    // A coordinate near a center, clipped to the coordinate range.
    function automatic longint pick_coord(longint centre, int unsigned spread);
        longint v;
        v = centre + longint'($urandom_range(2 * spread)) - longint'(spread);
        if (v > COORD_TOP)
            v = COORD_TOP;
        if (v < COORD_BOTTOM)
            v = COORD_BOTTOM;
        return v;
    endfunction

    // Offers one beat, with a random gap first unless the run is steady.
    task automatic send_beat(input pap_pkg::item_t it);
        if (!steady)
        begin
            while ($urandom_range(99) < 37)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        board.apply_action(it);
        if (it.action != ACT_NONE)
            beats_in++;
    endtask

    // Holds the sender until every owed result has been delivered.
    task automatic wait_for_results(input bit hold_off);
        item_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        if (hold_off)
            repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_radius(input logic [pap_pkg::RADIUS_W-1:0] r);
        wait_for_results(1'b1);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= r;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_radius(r);
    endtask

    // Random polygons: mostly well formed, ended in the different ways,
    // with some ignored codes and polygons left open to run into the next one.
    task automatic run_polygons(input int target, input bit full_range);
        int start;
        int verts;
        int n;
        int pick;
        int unsigned spread;
        longint cx;
        longint cy;
        longint fx;
        longint fy;
        longint x;
        longint y;
        start = beats_in;
        fx = 0;
        fy = 0;
        while (beats_in - start < target)
        begin
            verts = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
            case ($urandom_range(3))
                0: spread = 16;
                1: spread = 4096;
                2: spread = 65536;
                default: spread = 1 << 20;
            endcase
            cx = full_coord();
            cy = full_coord();
            for (n = 0; n < verts; n++)
            begin
                if ($urandom_range(24) == 0)
                    send_beat(make_item(ACT_NONE, full_coord(), full_coord()));
                if (full_range || $urandom_range(4) == 0)
                begin
                    x = full_coord();
                    y = full_coord();
                end
                else
                begin
                    x = pick_coord(cx, spread);
                    y = pick_coord(cy, spread);
                end
                if (n == 0)
                begin
                    fx = x;
                    fy = y;
                end
                send_beat(make_item(pap_pkg::ACT_ADD, x, y));
            end
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                send_beat(make_item(pap_pkg::ACT_FINISH, full_coord(), full_coord()));
            end
            else if (pick < 75 && board.radius != 0)
            begin
                spread = 32'(board.radius[23:0] >> 1);
                send_beat(make_item(pap_pkg::ACT_ADD, pick_coord(fx, spread),
                                    pick_coord(fy, spread)));
            end
            else if (pick < 85)
            begin
                send_beat(make_item(pap_pkg::ACT_CANCEL, full_coord(), full_coord()));
            end
            else if (pick < 92)
            begin
                send_beat(make_item(pap_pkg::ACT_FINISH, 0, 0));
                send_beat(make_item(pap_pkg::ACT_FINISH, 0, 0));
            end
        end
    endtask

    initial
    begin
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: finishes that are too short, ignored code, extreme square.
        write_radius(24'd0);
        send_beat(make_item(pap_pkg::ACT_FINISH, 0, 0));
        send_beat(make_item(pap_pkg::ACT_ADD, COORD_BOTTOM, COORD_BOTTOM));
        send_beat(make_item(pap_pkg::ACT_FINISH, 0, 0));
        send_beat(make_item(pap_pkg::ACT_ADD, COORD_TOP, COORD_BOTTOM));
        send_beat(make_item(pap_pkg::ACT_FINISH, 0, 0));
        send_beat(make_item(ACT_NONE, COORD_TOP, COORD_TOP));
        send_beat(make_item(pap_pkg::ACT_ADD, COORD_TOP, COORD_TOP));
        send_beat(make_item(pap_pkg::ACT_ADD, COORD_BOTTOM, COORD_TOP));
        send_beat(make_item(pap_pkg::ACT_FINISH, 0, 0));

        // Cancel drops a partial polygon; a finish after it does nothing.
        send_beat(make_item(pap_pkg::ACT_ADD, 0, 0));
        send_beat(make_item(pap_pkg::ACT_ADD, 4096, 0));
        send_beat(make_item(pap_pkg::ACT_CANCEL, 0, 0));
        send_beat(make_item(pap_pkg::ACT_FINISH, 0, 0));

        // Collinear vertices give zero area.
        send_beat(make_item(pap_pkg::ACT_ADD, 0, 0));
        send_beat(make_item(pap_pkg::ACT_ADD, 2, 2));
        send_beat(make_item(pap_pkg::ACT_ADD, 5, 5));
        send_beat(make_item(pap_pkg::ACT_FINISH, 0, 0));

        // Closing by distance: exactly at the radius does not close,
        // just inside it does, and fewer than three held never closes.
        write_radius(24'd4096);
        send_beat(make_item(pap_pkg::ACT_ADD, 0, 0));
        send_beat(make_item(pap_pkg::ACT_ADD, 40960, 0));
        send_beat(make_item(pap_pkg::ACT_ADD, 0, 40960));
        send_beat(make_item(pap_pkg::ACT_ADD, 4096, 0));
        send_beat(make_item(pap_pkg::ACT_ADD, 0, 4095));
        send_beat(make_item(pap_pkg::ACT_ADD, 100, 100));
        send_beat(make_item(pap_pkg::ACT_ADD, 50, 50));
        send_beat(make_item(pap_pkg::ACT_CANCEL, 0, 0));

        // Random phases over several radius settings.
        write_radius(24'd0);
        run_polygons(100, 1'b0);
        write_radius(24'd1);
        run_polygons(80, 1'b0);
        write_radius(24'hFF_FFFF);
        run_polygons(80, 1'b1);

        // A stretch with no idling on either side.
        steady = 1'b1;
        write_radius(pap_pkg::RADIUS_W'($urandom_range(256, 65535)));
        run_polygons(100, 1'b0);
        steady = 1'b0;

        // The sender pauses halfway until everything owed has come back.
        write_radius(pap_pkg::RADIUS_W'($urandom_range(1, 24'hFF_FFFF)));
        run_polygons(60, 1'b0);
        wait_for_results(1'b0);
        run_polygons(60, 1'b0);

        wait_for_results(1'b1);
        $display("Summary: %0d input beats, %0d polygons measured over six radius settings.",
                 beats_in, board.polygons);
        $display("Summary: short finishes, cancels, ignored codes and distance closes covered.");
        if (board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pap_pkg.sv
hw/rtl/polygon_area_perimeter_top.sv
hw/rtl/pap_checker.sv
tb/tb_polygon_area_perimeter_top.sv
